// ===== rtl/cmfs_pkg.sv =====
// ----------------------------------------------------------------------------
// cmfs_pkg: shared definitions for the cube-map face selector
// Face codes and the bit positions of the result flags carried in tuser.
// ----------------------------------------------------------------------------
package cmfs_pkg;

  typedef logic [2:0] face_t;

  localparam face_t FACE_POS_X = 3'd0;
  localparam face_t FACE_NEG_X = 3'd1;
  localparam face_t FACE_POS_Y = 3'd2;
  localparam face_t FACE_NEG_Y = 3'd3;
  localparam face_t FACE_POS_Z = 3'd4;
  localparam face_t FACE_NEG_Z = 3'd5;

  localparam int FACE_BITS = 3;

  // Bit positions inside out_tuser.
  localparam int USER_FALLBACK = 0;
  localparam int USER_ZERO_DIR = 1;
  localparam int USER_BITS     = 2;

endpackage

// ===== rtl/cube_map_face_select.sv =====
// ----------------------------------------------------------------------------
// cube_map_face_select: cube-map face selection and face-coordinate projection
// Picks the major axis of a direction vector and projects the two minor
// components onto that face as unsigned fixed-point coordinates.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ channel carries one direction word: dir_x, dir_y and dir_z, each a
//   signed COMPONENT_BITS value. The out_ channel returns one word per input:
//   face and tex_u, tex_v in tdata, fallback and zero_direction in tuser.
//   cfg_wr_en with cfg_wr_data sets faces_loaded; write it only while idle.
//   While faces_loaded is 0 every result has fallback set and all else zero.
//   An accepted word passes the input register, the select and offset stages,
//   the divider and the output register. The divider is a restoring array of
//   COORD_BITS + 1 registered stages, one quotient bit per stage, working on
//   u and v side by side; with select, offset, rounding and the input and
//   output registers it gives a one-word-per-cycle pipeline if out_tready is high.
//   Every stage has its own valid bit and loads when empty or when the stage
//   after it can take its word, so a stalled receiver first lets the pipeline
//   close its bubbles; in_tready drops only once all stages are full.
//   Reset clears all valid bits and faces_loaded.
// ----------------------------------------------------------------------------
module cube_map_face_select
  import cmfs_pkg::*;
#(
  parameter int COMPONENT_BITS = 16,
  parameter int COORD_BITS     = 16
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          cfg_wr_en,
  input  logic                                          cfg_wr_data,
  input  logic                                          in_tvalid,
  output logic                                          in_tready,
  // Fields from bit 0 up: dir_x, dir_y, dir_z, zero fill.
  input  logic [((3*COMPONENT_BITS+7)/8)*8-1:0]         in_tdata,
  output logic                                          out_tvalid,
  input  logic                                          out_tready,
  // Fields from bit 0 up: face, tex_u, tex_v, zero fill.
  output logic [((FACE_BITS+2*COORD_BITS+7)/8)*8-1:0]   out_tdata,
  // Fields from bit 0 up: fallback, zero_direction.
  output logic [USER_BITS-1:0]                          out_tuser
);

  localparam int CB     = COMPONENT_BITS;
  localparam int C      = COORD_BITS;
  localparam int OUT_W  = ((FACE_BITS + 2*C + 7) / 8) * 8;
  localparam int PAD_W  = OUT_W - FACE_BITS - 2*C;

  logic faces_loaded_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      faces_loaded_r <= 1'b0;
    end else if (cfg_wr_en) begin
      faces_loaded_r <= cfg_wr_data;
    end
  end

  // Ready chain: a stage loads when it is empty or its successor loads.
  logic s0_rdy, s1_rdy, s2_rdy, o_rdy;
  logic dv_rdy [C+1];

  // Stage 0: captured input.
  logic          s0_v_r;
  logic [CB-1:0] s0_x_r, s0_y_r, s0_z_r;
  logic          s0_fb_r;

  assign s0_rdy    = !s0_v_r || s1_rdy;
  assign in_tready = s0_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (s0_rdy) begin
      s0_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_rdy && in_tvalid) begin
      s0_x_r  <= in_tdata[CB-1:0];
      s0_y_r  <= in_tdata[2*CB-1:CB];
      s0_z_r  <= in_tdata[3*CB-1:2*CB];
      s0_fb_r <= !faces_loaded_r;
    end
  end

  // Stage 1: major axis, face, magnitude and signed minor components.
  logic          s1_v_r;
  face_t         s1_face_r;
  logic [CB-1:0] s1_m_r;
  logic [CB:0]   s1_sc_r, s1_tc_r;
  logic          s1_fb_r;

  logic [CB-1:0] ax, ay, az;
  logic [CB:0]   xe, ye, ze, nxe, nye, nze;
  face_t         face_nxt;
  logic [CB-1:0] m_nxt;
  logic [CB:0]   sc_nxt, tc_nxt;

  always_comb begin
    ax  = s0_x_r[CB-1] ? CB'(-s0_x_r) : s0_x_r;
    ay  = s0_y_r[CB-1] ? CB'(-s0_y_r) : s0_y_r;
    az  = s0_z_r[CB-1] ? CB'(-s0_z_r) : s0_z_r;
    xe  = {s0_x_r[CB-1], s0_x_r};
    ye  = {s0_y_r[CB-1], s0_y_r};
    ze  = {s0_z_r[CB-1], s0_z_r};
    nxe = -xe;
    nye = -ye;
    nze = -ze;
    priority if (ax >= ay && ax >= az) begin
      m_nxt  = ax;
      tc_nxt = nye;
      // Positive only when strictly above zero.
      if (!s0_x_r[CB-1] && (s0_x_r != '0)) begin
        face_nxt = FACE_POS_X;
        sc_nxt   = nze;
      end else begin
        face_nxt = FACE_NEG_X;
        sc_nxt   = ze;
      end
    end else if (ay >= az) begin
      m_nxt  = ay;
      sc_nxt = xe;
      if (!s0_y_r[CB-1] && (s0_y_r != '0)) begin
        face_nxt = FACE_POS_Y;
        tc_nxt   = ze;
      end else begin
        face_nxt = FACE_NEG_Y;
        tc_nxt   = nze;
      end
    end else begin
      m_nxt  = az;
      tc_nxt = nye;
      if (!s0_z_r[CB-1] && (s0_z_r != '0)) begin
        face_nxt = FACE_POS_Z;
        sc_nxt   = xe;
      end else begin
        face_nxt = FACE_NEG_Z;
        sc_nxt   = nxe;
      end
    end
  end

  assign s1_rdy = !s1_v_r || s2_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_rdy) begin
      s1_v_r <= s0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy && s0_v_r) begin
      s1_face_r <= face_nxt;
      s1_m_r    <= m_nxt;
      s1_sc_r   <= sc_nxt;
      s1_tc_r   <= tc_nxt;
      s1_fb_r   <= s0_fb_r;
    end
  end

  // Stage 2: shift the minor components into [0, 2m] and form the divisor 2m.
  logic          s2_v_r;
  face_t         s2_face_r;
  logic [CB-1:0] s2_m_r;
  logic [CB:0]   s2_d_r, s2_nu_r, s2_nv_r;
  logic          s2_zero_r, s2_fb_r;

  assign s2_rdy = !s2_v_r || dv_rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_rdy) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_rdy && s1_v_r) begin
      s2_face_r <= s1_face_r;
      s2_m_r    <= s1_m_r;
      s2_d_r    <= {s1_m_r, 1'b0};
      s2_nu_r   <= s1_sc_r + {1'b0, s1_m_r};
      s2_nv_r   <= s1_tc_r + {1'b0, s1_m_r};
      s2_zero_r <= (s1_m_r == '0);
      s2_fb_r   <= s1_fb_r;
    end
  end

  // Divider stages: one quotient bit of num * 2^C / 2m per stage, for u and v.
  logic          dv_v_r    [C+1];
  face_t         dv_face_r [C+1];
  logic [CB-1:0] dv_m_r    [C+1];
  logic [CB:0]   dv_d_r    [C+1];
  logic [CB:0]   dv_ru_r   [C+1];
  logic [CB:0]   dv_rv_r   [C+1];
  logic [C:0]    dv_qu_r   [C+1];
  logic [C:0]    dv_qv_r   [C+1];
  logic          dv_zero_r [C+1];
  logic          dv_fb_r   [C+1];

  for (genvar k = 0; k <= C; k++) begin : g_div
    logic          p_v;
    face_t         p_face;
    logic [CB-1:0] p_m;
    logic [CB:0]   p_d, p_ru, p_rv;
    logic [C:0]    p_qu, p_qv;
    logic          p_zero, p_fb, nx_rdy;
    logic [CB+1:0] tu, tv, dd;
    logic          bu, bv;

    if (k == 0) begin : g_first
      assign p_v    = s2_v_r;
      assign p_face = s2_face_r;
      assign p_m    = s2_m_r;
      assign p_d    = s2_d_r;
      assign p_ru   = s2_nu_r;
      assign p_rv   = s2_nv_r;
      assign p_qu   = '0;
      assign p_qv   = '0;
      assign p_zero = s2_zero_r;
      assign p_fb   = s2_fb_r;
      // The leading bit compares the offset value itself, unshifted.
      assign tu     = {1'b0, p_ru};
      assign tv     = {1'b0, p_rv};
    end else begin : g_next
      assign p_v    = dv_v_r[k-1];
      assign p_face = dv_face_r[k-1];
      assign p_m    = dv_m_r[k-1];
      assign p_d    = dv_d_r[k-1];
      assign p_ru   = dv_ru_r[k-1];
      assign p_rv   = dv_rv_r[k-1];
      assign p_qu   = dv_qu_r[k-1];
      assign p_qv   = dv_qv_r[k-1];
      assign p_zero = dv_zero_r[k-1];
      assign p_fb   = dv_fb_r[k-1];
      assign tu     = {p_ru, 1'b0};
      assign tv     = {p_rv, 1'b0};
    end

    if (k == C) begin : g_last
      assign nx_rdy = o_rdy;
    end else begin : g_mid
      assign nx_rdy = dv_rdy[k+1];
    end

    assign dd        = {1'b0, p_d};
    assign bu        = (tu >= dd);
    assign bv        = (tv >= dd);
    assign dv_rdy[k] = !dv_v_r[k] || nx_rdy;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[k] <= 1'b0;
      end else if (dv_rdy[k]) begin
        dv_v_r[k] <= p_v;
      end
    end

    always_ff @(posedge clk) begin
      if (dv_rdy[k] && p_v) begin
        dv_face_r[k] <= p_face;
        dv_m_r[k]    <= p_m;
        dv_d_r[k]    <= p_d;
        dv_ru_r[k]   <= bu ? (CB+1)'(tu - dd) : tu[CB:0];
        dv_rv_r[k]   <= bv ? (CB+1)'(tv - dd) : tv[CB:0];
        dv_qu_r[k]   <= {p_qu[C-1:0], bu};
        dv_qv_r[k]   <= {p_qv[C-1:0], bv};
        dv_zero_r[k] <= p_zero;
        dv_fb_r[k]   <= p_fb;
      end
    end
  end

  // Output stage: round half up (remainder at least m), saturate, special cases.
  logic          o_v_r;
  face_t         o_face_r;
  logic [C-1:0]  o_u_r, o_v_coord_r;
  logic          o_fb_r, o_zero_r;

  logic [C:0]    qu_rnd, qv_rnd;
  logic [C-1:0]  u_sat, v_sat;
  logic [C-1:0]  center;

  assign center = {1'b1, {(C-1){1'b0}}};

  always_comb begin
    qu_rnd = dv_qu_r[C] + (C+1)'(dv_ru_r[C] >= {1'b0, dv_m_r[C]});
    qv_rnd = dv_qv_r[C] + (C+1)'(dv_rv_r[C] >= {1'b0, dv_m_r[C]});
    u_sat  = qu_rnd[C] ? {C{1'b1}} : qu_rnd[C-1:0];
    v_sat  = qv_rnd[C] ? {C{1'b1}} : qv_rnd[C-1:0];
  end

  assign o_rdy = !o_v_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (o_rdy) begin
      o_v_r <= dv_v_r[C];
    end
  end

  always_ff @(posedge clk) begin
    if (o_rdy && dv_v_r[C]) begin
      if (dv_fb_r[C]) begin
        o_face_r    <= FACE_POS_X;
        o_u_r       <= '0;
        o_v_coord_r <= '0;
        o_fb_r      <= 1'b1;
        o_zero_r    <= 1'b0;
      end else if (dv_zero_r[C]) begin
        o_face_r    <= dv_face_r[C];
        o_u_r       <= center;
        o_v_coord_r <= center;
        o_fb_r      <= 1'b0;
        o_zero_r    <= 1'b1;
      end else begin
        o_face_r    <= dv_face_r[C];
        o_u_r       <= u_sat;
        o_v_coord_r <= v_sat;
        o_fb_r      <= 1'b0;
        o_zero_r    <= 1'b0;
      end
    end
  end

  assign out_tvalid = o_v_r;
  if (PAD_W > 0) begin : g_pad
    assign out_tdata = {{PAD_W{1'b0}}, o_v_coord_r, o_u_r, o_face_r};
  end else begin : g_nopad
    assign out_tdata = {o_v_coord_r, o_u_r, o_face_r};
  end
  assign out_tuser[USER_FALLBACK] = o_fb_r;
  assign out_tuser[USER_ZERO_DIR] = o_zero_r;

  // A fallback word carries nothing else.
  a_fallback_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[USER_FALLBACK] |->
      out_tdata == '0 && !out_tuser[USER_ZERO_DIR])
    else $error("fallback word with nonzero fields");

  // The all-zero vector falls to -X by the tie rule and sits at face center.
  a_zero_center: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[USER_ZERO_DIR] |->
      out_tdata[FACE_BITS-1:0] == FACE_NEG_X &&
      out_tdata[FACE_BITS+C-1:FACE_BITS] == center &&
      out_tdata[FACE_BITS+2*C-1:FACE_BITS+C] == center)
    else $error("zero direction word not centered on -X");

  a_face_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[FACE_BITS-1:0] <= FACE_NEG_Z)
    else $error("face code out of range");

  // With the output register empty every stage can move, so input is open.
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled while output register is empty");

endmodule

// ===== tb/cube_map_face_select_tb.sv =====
// ----------------------------------------------------------------------------
// cube_map_face_select_tb: self-checking bench for the cube-map face selector
// Drives direction words with bursty traffic against a stalling receiver,
// predicts face, u, v and the two flags for every accepted word, and checks
// each result word in order against those predictions.
// ----------------------------------------------------------------------------
module cube_map_face_select_tb;
  import cmfs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int COMP_BITS    = 16;
  localparam int UV_BITS      = 16;
  localparam int IN_W         = ((3*COMP_BITS+7)/8)*8;
  localparam int OUT_W        = ((FACE_BITS+2*UV_BITS+7)/8)*8;
  localparam int PIPE_LATENCY = UV_BITS + 4;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int PRINT_LIMIT  = 100;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_RUNS} rx_mode_t;

  // x sits in the low bits so the struct packs straight into in_tdata.
  typedef struct packed {
    logic signed [COMP_BITS-1:0] z;
    logic signed [COMP_BITS-1:0] y;
    logic signed [COMP_BITS-1:0] x;
  } dir_t;

  typedef struct packed {
    face_t              face;
    logic [UV_BITS-1:0] tex_u;
    logic [UV_BITS-1:0] tex_v;
    logic               fallback;
    logic               zero_dir;
  } face_result_t;

  typedef struct packed {
    dir_t         dir;
    face_result_t res;
  } lookup_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  logic             cfg_wr_data;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;
  logic [USER_BITS-1:0] out_tuser;

  lookup_t  pending_lookups[$];
  bit       faces_loaded_copy = 1'b0;
  int       error_count = 0;
  bit       sender_idling = 1'b1;
  int       burst_left = 0;
  rx_mode_t rx_mode = RX_RANDOM;
  int       hold_request = 0;

  cube_map_face_select #(
    .COMPONENT_BITS(COMP_BITS),
    .COORD_BITS    (UV_BITS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= PRINT_LIMIT) begin
      $display("%0t ns ERROR %s", $time, msg);
    end
  endtask

  // Maps sc in [-m, m] to unsigned Q0.UV_BITS, rounding halves up.
  function automatic logic [UV_BITS-1:0] uv_coord(input longint sc, input longint m);
    longint q;
    q = (((sc + m) <<< UV_BITS) + m) / (2 * m);
    if (q > (longint'(1) <<< UV_BITS) - 1) begin
      q = (longint'(1) <<< UV_BITS) - 1;
    end
    return q[UV_BITS-1:0];
  endfunction

  function automatic face_result_t project_direction(input dir_t d, input bit loaded);
    face_result_t r;
    longint x, y, z, ax, ay, az, m, sc, tc;
    r = '0;
    if (!loaded) begin
      r.fallback = 1'b1;
      return r;
    end
    x  = longint'($signed(d.x));
    y  = longint'($signed(d.y));
    z  = longint'($signed(d.z));
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    az = (z < 0) ? -z : z;
    // Ties favor X over Y over Z.
    if (ax >= ay && ax >= az) begin
      m = ax;
      if (x > 0) begin
        r.face = FACE_POS_X; sc = -z; tc = -y;
      end else begin
        r.face = FACE_NEG_X; sc = z;  tc = -y;
      end
    end else if (ay >= az) begin
      m = ay;
      if (y > 0) begin
        r.face = FACE_POS_Y; sc = x; tc = z;
      end else begin
        r.face = FACE_NEG_Y; sc = x; tc = -z;
      end
    end else begin
      m = az;
      if (z > 0) begin
        r.face = FACE_POS_Z; sc = x;  tc = -y;
      end else begin
        r.face = FACE_NEG_Z; sc = -x; tc = -y;
      end
    end
    if (m == 0) begin
      r.tex_u    = UV_BITS'(1) << (UV_BITS - 1);
      r.tex_v    = UV_BITS'(1) << (UV_BITS - 1);
      r.zero_dir = 1'b1;
    end else begin
      r.tex_u = uv_coord(sc, m);
      r.tex_v = uv_coord(tc, m);
    end
    return r;
  endfunction

  // Leaves in_tvalid high on return so back-to-back words need no toggle.
  task automatic send_direction(input dir_t d);
    lookup_t rec;
    if (sender_idling) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      burst_left--;
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_W'(d);
    do @(posedge clk); while (!in_tready);
    rec.dir = d;
    rec.res = project_direction(d, faces_loaded_copy);
    pending_lookups.push_back(rec);
  endtask

  task automatic send_xyz(input int x, input int y, input int z);
    dir_t d;
    d.x = x[COMP_BITS-1:0];
    d.y = y[COMP_BITS-1:0];
    d.z = z[COMP_BITS-1:0];
    send_direction(d);
  endtask

  function automatic logic [COMP_BITS-1:0] pick_component();
    case ($urandom_range(0, 9))
      0: return {1'b1, {(COMP_BITS-1){1'b0}}};
      1: return {1'b0, {(COMP_BITS-1){1'b1}}};
      2: return '0;
      3: return COMP_BITS'($urandom_range(0, 8) - 4);
      default: return COMP_BITS'($urandom());
    endcase
  endfunction

  function automatic dir_t pick_direction();
    dir_t d;
    int base;
    if ($urandom_range(0, 3) == 0) begin
      // Magnitudes equal or at most two apart to hammer the tie-break.
      base = $urandom_range(0, 32767);
      d.x = COMP_BITS'(($urandom_range(0, 1) ? base : -base) + $urandom_range(0, 2) - 1);
      d.y = COMP_BITS'(($urandom_range(0, 1) ? base : -base) + $urandom_range(0, 2) - 1);
      d.z = COMP_BITS'(($urandom_range(0, 1) ? base : -base) + $urandom_range(0, 2) - 1);
      if ($urandom_range(0, 3) == 0) d.z = '0;
    end else begin
      d.x = pick_component();
      d.y = pick_component();
      d.z = pick_component();
    end
    return d;
  endfunction

  task automatic drain_results();
    int waited;
    in_tvalid <= 1'b0;
    waited = 0;
    while (pending_lookups.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_lookups.size() != 0) begin
      report_mismatch($sformatf("%0d result words never arrived", pending_lookups.size()));
      pending_lookups.delete();
    end
    repeat (PIPE_LATENCY + 4) @(posedge clk);
  endtask

  task automatic load_faces(input bit loaded);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= loaded;
    @(posedge clk);
    faces_loaded_copy = loaded;
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_random(input int count);
    repeat (count) send_direction(pick_direction());
  endtask

  // Straight after reset the faces are not loaded, so everything falls back.
  task automatic test_fallback_after_reset();
    send_xyz(0, 0, 0);
    send_xyz(32767, -32768, 1);
    send_xyz(-32768, 32767, -1);
    send_xyz(0, 0, -32768);
    send_random(8);
  endtask

  task automatic test_directed_corners();
    load_faces(1'b1);
    send_xyz(0, 0, 0);
    send_xyz(32767, 0, 0);
    send_xyz(-32768, 0, 0);
    send_xyz(0, 32767, 0);
    send_xyz(0, -32768, 0);
    send_xyz(0, 0, 32767);
    send_xyz(0, 0, -32768);
    send_xyz(5, 5, 5);
    send_xyz(-5, 5, -5);
    send_xyz(0, 7, -7);
    send_xyz(0, -7, 7);
    send_xyz(-3, 2, -3);
    send_xyz(10, 0, -10);
    send_xyz(-32768, -32768, -32768);
    send_xyz(-32768, 32767, 32767);
    send_xyz(32767, -32768, 0);
    send_xyz(1, 1, 1);
    send_xyz(1, 0, 0);
    send_xyz(-1, 1, 0);
    send_xyz(0, 0, 1);
    send_xyz(0, 0, -1);
    send_xyz(100, -33, 67);
    send_xyz(-20000, 20001, -19999);
  endtask

  task automatic test_random_directions();
    for (int i = 0; i < 8; i++) begin
      rx_mode       = rx_mode_t'(i % 3);
      sender_idling = (i != 5);
      send_random(140);
    end
  endtask

  // A long receiver hold-off lets the pipeline fill and push back on input.
  task automatic test_receiver_hold_off();
    drain_results();
    sender_idling = 1'b0;
    rx_mode       = RX_ALWAYS;
    hold_request  = 80;
    send_random(100);
    sender_idling = 1'b1;
    rx_mode       = RX_RANDOM;
  endtask

  task automatic test_config_toggling();
    load_faces(1'b0);
    send_random(60);
    load_faces(1'b1);
    send_random(60);
  endtask

  task automatic test_full_rate();
    drain_results();
    sender_idling = 1'b0;
    rx_mode       = RX_ALWAYS;
    send_random(100);
  endtask

  initial begin : receiver
    int  hold_left;
    int  run_left;
    bit  run_ready;
    hold_left = 0;
    run_left  = 0;
    run_ready = 1'b1;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_ALWAYS: out_tready <= 1'b1;
          RX_RANDOM: out_tready <= ($urandom_range(0, 99) < 65);
          default: begin
            if (run_left == 0) begin
              run_ready = ~run_ready;
              run_left  = run_ready ? $urandom_range(1, 12) : $urandom_range(1, 6);
            end
            run_left--;
            out_tready <= run_ready;
          end
        endcase
      end
    end
  end

  always @(posedge clk) begin : result_check
    lookup_t      want;
    face_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.face     = out_tdata[FACE_BITS-1:0];
      got.tex_u    = out_tdata[FACE_BITS +: UV_BITS];
      got.tex_v    = out_tdata[FACE_BITS+UV_BITS +: UV_BITS];
      got.fallback = out_tuser[USER_FALLBACK];
      got.zero_dir = out_tuser[USER_ZERO_DIR];
      if (pending_lookups.size() == 0) begin
        report_mismatch($sformatf("result word with nothing pending: face %0d u %0d v %0d",
                                  got.face, got.tex_u, got.tex_v));
      end else begin
        want = pending_lookups.pop_front();
        if (got.face !== want.res.face || got.tex_u !== want.res.tex_u ||
            got.tex_v !== want.res.tex_v || got.fallback !== want.res.fallback ||
            got.zero_dir !== want.res.zero_dir) begin
          report_mismatch($sformatf(
            "dir (%0d,%0d,%0d) got f%0d u%0d v%0d fb%b z%b want f%0d u%0d v%0d fb%b z%b",
            want.dir.x, want.dir.y, want.dir.z,
            got.face, got.tex_u, got.tex_v, got.fallback, got.zero_dir,
            want.res.face, want.res.tex_u, want.res.tex_v,
            want.res.fallback, want.res.zero_dir));
        end
      end
    end
  end

  initial begin : stimulus
    rst_n       <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_fallback_after_reset();
    test_directed_corners();
    test_random_directions();
    test_receiver_hold_off();
    test_config_toggling();
    test_full_rate();
    drain_results();
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
